[rtl/bsli_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsli_pkg
// Shared types and constants for the bounded sorted list insert block.
// ----------------------------------------------------------------------------
package bsli_pkg;

    localparam int KEY_W      = 64;  // key field width on the ports
    localparam int CNT_W      = 7;   // entry count and capacity width
    localparam int DATA_W     = 32;  // configuration data width
    localparam int ADDR_W     = 3;   // configuration byte address width

    localparam int CAPACITY_DEF  = 64;
    localparam int KEY_WIDTH_DEF = 64;

    localparam logic [CNT_W-1:0] CAPACITY_RESET = 7'd10;

    // register index, taken from the word address bits of paddr
    localparam logic REG_CAPACITY = 1'b0;

    // request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DUMP   = 1'b1;

    // result status codes
    localparam logic [1:0] STS_INSERTED = 2'd0;
    localparam logic [1:0] STS_OVERFLOW = 2'd1;
    localparam logic [1:0] STS_DUMPED   = 2'd2;
    localparam logic [1:0] STS_EMPTY    = 2'd3;

    typedef struct packed {
        logic             req_type;
        logic [KEY_W-1:0] key;
    } t_in_word;

    typedef struct packed {
        logic [1:0]       status;
        logic [KEY_W-1:0] entry_key;
        logic [CNT_W-1:0] entry_count;
        logic             last;
    } t_out_word;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic insert;  // place the new key, shift larger and equal keys up
        logic rotate;  // move every valid key one cell toward the head
    } t_cell_cmd;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } t_state;

endpackage

[rtl/bsli_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsli_cell
// One slot of the sorted chain: holds a key and its valid flag.
// ----------------------------------------------------------------------------
module bsli_cell #(
    parameter int KEY_WIDTH = bsli_pkg::KEY_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bsli_pkg::t_cell_cmd  i_cmd,
    input  logic [KEY_WIDTH-1:0] i_new_key,
    input  logic [KEY_WIDTH-1:0] i_head_key,
    input  logic                 i_prev_take,
    input  logic                 i_prev_valid,
    input  logic [KEY_WIDTH-1:0] i_prev_key,
    input  logic                 i_next_valid,
    input  logic [KEY_WIDTH-1:0] i_next_key,
    output logic                 o_take,
    output logic                 o_valid,
    output logic [KEY_WIDTH-1:0] o_key
);
    import bsli_pkg::*;

    logic                 r_valid;
    logic                 n_valid;
    logic [KEY_WIDTH-1:0] r_key;
    logic [KEY_WIDTH-1:0] n_key;

    // new key belongs here or before this cell
    assign o_take  = !r_valid || (r_key >= i_new_key);
    assign o_valid = r_valid;
    assign o_key   = r_key;

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        if (i_cmd.insert) begin
            if (i_prev_take && i_prev_valid) begin
                // shift up from the neighbor below
                n_key   = i_prev_key;
                n_valid = 1'b1;
            end else if (o_take && !i_prev_take) begin
                n_key   = i_new_key;
                n_valid = 1'b1;
            end
        end else if (i_cmd.rotate) begin
            // last valid cell wraps the head key around
            n_key = i_next_valid ? i_next_key : i_head_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

[rtl/bounded_sorted_list_insert.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_sorted_list_insert
// Ascending list of keys with a capacity limit, insert and in-order dump.
// ----------------------------------------------------------------------------
// The list lives in a chain of CAPACITY cells, each holding one key and a
// valid flag. On an insert every cell compares the new key against its own
// key at once, the cell at the insert point loads the new key and every cell
// above it loads its lower neighbor, so inserts can arrive on consecutive
// cycles while the output is taken. A new key goes ahead of equal keys. An
// insert when the count has reached the capacity register (saturated to
// CAPACITY) returns overflow and leaves the list as it is. A dump word moves
// the block into its dump state and then streams one result word per stored
// entry, one per cycle while the output is taken; the chain rotates toward
// the head once per entry, so after the last word the list is back in its
// original order. No new input word is taken during a dump. A dump of an
// empty list returns one empty word. Results sit in an output register, so the
// next insert is taken in the same cycle the previous result leaves. The
// capacity register sits at byte address 0 of the APB port; keys wider than
// KEY_WIDTH keep their low bits only.
// ----------------------------------------------------------------------------
module bounded_sorted_list_insert #(
    parameter int CAPACITY  = bsli_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = bsli_pkg::KEY_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  bsli_pkg::t_in_word            i_in_data,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output bsli_pkg::t_out_word           o_out_data,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bsli_pkg::ADDR_W-1:0]   paddr,
    input  logic [bsli_pkg::DATA_W-1:0]   pwdata,
    output logic [bsli_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import bsli_pkg::*;

    // ---- configuration -----------------------------------------------------
    logic [CNT_W-1:0] r_capacity;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CAPACITY) ? DATA_W'(r_capacity) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_CAPACITY)) begin
            r_capacity <= pwdata[CNT_W-1:0];
        end
    end

    // ---- control state -----------------------------------------------------
    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] r_idx;       // entries emitted so far in a dump
    logic [CNT_W-1:0] n_idx;
    logic             r_out_valid;
    logic             n_out_valid;
    t_out_word        r_out_data;
    t_out_word        n_out_data;

    t_cell_cmd        w_cmd;
    logic             w_out_free;
    logic             w_accept;
    logic             w_full;
    logic [KEY_WIDTH-1:0] w_new_key;

    // ---- cell chain --------------------------------------------------------
    logic                 w_take  [CAPACITY];
    logic                 w_valid [CAPACITY];
    logic [KEY_WIDTH-1:0] w_key   [CAPACITY];

    assign w_new_key = i_in_data.key[KEY_WIDTH-1:0];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                 w_prev_take;
        logic                 w_prev_valid;
        logic [KEY_WIDTH-1:0] w_prev_key;
        logic                 w_next_valid;
        logic [KEY_WIDTH-1:0] w_next_key;

        if (g == 0) begin : g_head
            assign w_prev_take  = 1'b0;
            assign w_prev_valid = 1'b0;
            assign w_prev_key   = '0;
        end else begin : g_body
            assign w_prev_take  = w_take[g-1];
            assign w_prev_valid = w_valid[g-1];
            assign w_prev_key   = w_key[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_next_valid = 1'b0;
            assign w_next_key   = '0;
        end else begin : g_link
            assign w_next_valid = w_valid[g+1];
            assign w_next_key   = w_key[g+1];
        end

        bsli_cell #(
            .KEY_WIDTH (KEY_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_new_key    (w_new_key),
            .i_head_key   (w_key[0]),
            .i_prev_take  (w_prev_take),
            .i_prev_valid (w_prev_valid),
            .i_prev_key   (w_prev_key),
            .i_next_valid (w_next_valid),
            .i_next_key   (w_next_key),
            .o_take       (w_take[g]),
            .o_valid      (w_valid[g]),
            .o_key        (w_key[g])
        );
    end

    // ---- handshake ---------------------------------------------------------
    // output slot can take a word when empty or being drained this cycle
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE) && w_out_free;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // overflow once count reaches the register or the chain length
    assign w_full = (r_count >= r_capacity) || (32'(r_count) >= 32'(CAPACITY));

    // ---- next state --------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid && !i_out_ready;
        w_cmd       = '0;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_in_data.req_type == REQ_INSERT) begin
                        n_out_valid            = 1'b1;
                        n_out_data.entry_key   = '0;
                        n_out_data.last        = 1'b1;
                        if (w_full) begin
                            // drop the key, report overflow
                            n_out_data.status      = STS_OVERFLOW;
                            n_out_data.entry_count = r_count;
                        end else begin
                            w_cmd.insert           = 1'b1;
                            n_count                = r_count + 1'b1;
                            n_out_data.status      = STS_INSERTED;
                            n_out_data.entry_count = r_count + 1'b1;
                        end
                    end else if (r_count == '0) begin
                        n_out_valid            = 1'b1;
                        n_out_data.status      = STS_EMPTY;
                        n_out_data.entry_key   = '0;
                        n_out_data.entry_count = '0;
                        n_out_data.last        = 1'b1;
                    end else begin
                        // start streaming from the head cell
                        n_idx   = '0;
                        n_state = ST_DUMP;
                    end
                end
            end
            ST_DUMP: begin
                if (w_out_free) begin
                    // emit head, rotate chain by one entry
                    w_cmd.rotate           = 1'b1;
                    n_out_valid            = 1'b1;
                    n_out_data.status      = STS_DUMPED;
                    n_out_data.entry_key   = KEY_W'(w_key[0]);
                    n_out_data.entry_count = r_count;
                    n_out_data.last        = (r_idx == r_count - 1'b1);
                    n_idx                  = r_idx + 1'b1;
                    if (r_idx == r_count - 1'b1) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ---- registers ---------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

endmodule

[tb/bsli_list_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsli_list_checker
// Watches both word channels and the APB port of the sorted list block, keeps
// its own copy of the list and capacity, and checks each result word in order.
// ----------------------------------------------------------------------------
module bsli_list_checker #(
    parameter int CAPACITY  = bsli_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = bsli_pkg::KEY_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  bsli_pkg::t_in_word            i_in_data,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  bsli_pkg::t_out_word           i_out_data,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [bsli_pkg::ADDR_W-1:0]   i_paddr,
    input  logic [bsli_pkg::DATA_W-1:0]   i_pwdata,
    input  logic                          i_pready,
    output int                            o_pending,
    output int                            o_fail_count
);
    import bsli_pkg::*;

    localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_WIDTH);

    logic [KEY_W-1:0] list_keys [CAPACITY];
    int               list_count = 0;
    logic [CNT_W-1:0] list_capacity = CAPACITY_RESET;
    t_out_word        pending_results [$];
    int               mismatch_total = 0;

    function automatic int usable_capacity();
        return (int'(list_capacity) > CAPACITY) ? CAPACITY : int'(list_capacity);
    endfunction

    function automatic int field_differs(string field, logic [KEY_W-1:0] want,
                                         logic [KEY_W-1:0] got);
        if (want === got)
            return 0;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        return 1;
    endfunction

    // Update the list for one request and queue the result words it causes.
    task automatic apply_request(input t_in_word req);
        t_out_word        res;
        logic [KEY_W-1:0] new_key;
        int               pos;
        int               idx;
        res     = '0;
        new_key = req.key & KEY_MASK;
        if (req.req_type == REQ_INSERT) begin
            res.last = 1'b1;
            if (list_count >= usable_capacity()) begin
                res.status = STS_OVERFLOW;
            end else begin
                pos = 0;
                while (pos < list_count && list_keys[pos] < new_key)
                    pos++;
                for (idx = list_count; idx > pos; idx--)
                    list_keys[idx] = list_keys[idx-1];
                list_keys[pos] = new_key;
                list_count++;
                res.status = STS_INSERTED;
            end
            res.entry_count = CNT_W'(list_count);
            pending_results.push_back(res);
        end else if (list_count == 0) begin
            res.status = STS_EMPTY;
            res.last   = 1'b1;
            pending_results.push_back(res);
        end else begin
            for (idx = 0; idx < list_count; idx++) begin
                res.status      = STS_DUMPED;
                res.entry_key   = list_keys[idx];
                res.entry_count = CNT_W'(list_count);
                res.last        = (idx == list_count - 1);
                pending_results.push_back(res);
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_word want;
        if (!i_rst_n) begin
            list_count    = 0;
            list_capacity = CAPACITY_RESET;
            pending_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    mismatch_total++;
                    $display("%0t: unexpected result word, expected none, got %0h",
                             $time, i_out_data);
                end else begin
                    want = pending_results.pop_front();
                    mismatch_total += field_differs("status", KEY_W'(want.status),
                                                    KEY_W'(i_out_data.status));
                    mismatch_total += field_differs("entry_key", want.entry_key,
                                                    i_out_data.entry_key);
                    mismatch_total += field_differs("entry_count",
                                                    KEY_W'(want.entry_count),
                                                    KEY_W'(i_out_data.entry_count));
                    mismatch_total += field_differs("last", KEY_W'(want.last),
                                                    KEY_W'(i_out_data.last));
                end
            end
            if (i_in_valid && i_in_ready)
                apply_request(i_in_data);
            if (i_psel && i_penable && i_pwrite && i_pready
                    && i_paddr[ADDR_W-1:2] == REG_CAPACITY)
                list_capacity = i_pwdata[CNT_W-1:0];
        end
        o_pending    <= pending_results.size();
        o_fail_count <= mismatch_total;
    end

endmodule

[tb/tb_bounded_sorted_list_insert.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_sorted_list_insert
// Drives insert and dump words and APB capacity writes into the sorted list.
// ----------------------------------------------------------------------------
// A short directed run covers the empty dump, extreme and equal keys, packed
// string keys, the overflow at the reset capacity, a zero capacity and a write
// to an unused register. Random phases then step the capacity through
// several values, the saturating all-ones value among them. Both sides idle
// at random; the result side holds off once for a long stretch so the block
// stalls its request side. The checker beside the block does all prediction.
// ----------------------------------------------------------------------------
module tb_bounded_sorted_list_insert;
    import bsli_pkg::*;

    localparam int  RANDOM_PER_PHASE = 81;
    localparam int  HOLD_CYCLES      = 200;
    localparam int  DRAIN_LIMIT      = 20000;
    localparam int  SETTLE_CYCLES    = 20;
    localparam real RUN_LIMIT_NS     = 2000000.0;
    // address slot past the last register, written to check it is ignored
    localparam logic REG_UNUSED      = 1'b1;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    t_in_word            i_in_data   = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    t_out_word           o_out_data;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [ADDR_W-1:0]   paddr       = '0;
    logic [DATA_W-1:0]   pwdata      = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    int pending_words;
    int fail_count;

    // Long hold-off requests for the result side: it serves one per bump.
    int hold_req_cnt  = 0;
    int hold_done_cnt = 0;

    // Idle-free stretches for each side, toggled at random.
    bit send_steady = 1'b0;
    bit take_steady = 1'b0;

    // Capacity per random phase; all ones saturates to the full size.
    logic [DATA_W-1:0] phase_caps [5] = '{32'd20, 32'd45, 32'hFFFF_FFFF, 32'd64, 32'd1};

    always #1 i_clk = ~i_clk;

    bounded_sorted_list_insert u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    bsli_list_checker u_list_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_pending    (pending_words),
        .o_fail_count (fail_count)
    );

    // Mix key shapes: full random, a tiny range for duplicates, single bits and
    // the ends of the range, and short strings packed left-aligned.
    function automatic logic [KEY_W-1:0] random_key();
        logic [KEY_W-1:0] k;
        int               len;
        k = '0;
        case ($urandom_range(0, 5))
            1: k = KEY_W'($urandom_range(0, 7));
            2: begin
                case ($urandom_range(0, 2))
                    0: k = '0;
                    1: k = '1;
                    default: k = KEY_W'(1) << $urandom_range(0, KEY_W - 1);
                endcase
            end
            3: begin
                len = $urandom_range(1, 8);
                for (int b = 0; b < len; b++)
                    k[KEY_W-1-8*b -: 8] = 8'(8'h61 + $urandom_range(0, 25));
            end
            default: k = {$urandom, $urandom};
        endcase
        return k;
    endfunction

    // Offer one request word after a random gap and hold it until taken.
    // Keep valid high across back-to-back words: only drop it for a real gap.
    task automatic push_request(input logic req, input logic [KEY_W-1:0] key);
        t_in_word w;
        int       gap;
        w.req_type = req;
        w.key      = key;
        gap = send_steady ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 15) == 0)
            send_steady = !send_steady;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Drop valid and wait until every predicted result word has come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_register(input logic reg_index, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Result side: stall a random count per word, with idle-free stretches,
    // and serve a long hold-off whenever one is requested.
    initial begin : result_sink
        int stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req_cnt != hold_done_cnt) begin
                stall = HOLD_CYCLES;
                hold_done_cnt++;
            end else begin
                stall = take_steady ? 0 : $urandom_range(0, 7);
            end
            if ($urandom_range(0, 15) == 0)
                take_steady = !take_steady;
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        int waited;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset capacity of ten.
        push_request(REQ_DUMP, random_key());         // empty list: one empty word
        push_request(REQ_INSERT, '1);
        push_request(REQ_INSERT, '0);
        push_request(REQ_INSERT, '0);                 // equal key goes ahead of the first
        push_request(REQ_INSERT, 64'h8000_0000_0000_0000);
        push_request(REQ_INSERT, {"abc", 40'd0});
        push_request(REQ_INSERT, {"abd", 40'd0});
        push_request(REQ_INSERT, {"ab", 48'd0});      // prefix sorts ahead of longer string
        push_request(REQ_INSERT, 64'd1);
        push_request(REQ_INSERT, '1);
        push_request(REQ_INSERT, 64'h7FFF_FFFF_FFFF_FFFF);
        push_request(REQ_INSERT, 64'h1234_5678_9ABC_DEF0); // list full: overflow
        push_request(REQ_DUMP, '1);
        wait_drained();

        // Zero capacity, below the stored count: inserts overflow, dump keeps all.
        write_register(REG_CAPACITY, 32'd0);
        push_request(REQ_INSERT, 64'd5);
        push_request(REQ_DUMP, '0);
        wait_drained();

        // A write past the last register must leave the capacity alone.
        write_register(REG_UNUSED, 32'h0000_007F);
        push_request(REQ_INSERT, 64'd6);
        wait_drained();

        // Random phases, one capacity each.
        for (int p = 0; p < 5; p++) begin
            write_register(REG_CAPACITY, phase_caps[p]);
            // Block the result side for a long stretch while inserts keep coming.
            if (p == 1)
                hold_req_cnt <= hold_req_cnt + 1;
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (n == RANDOM_PER_PHASE / 2)
                    wait_drained();
                if ($urandom_range(0, 3) == 0)
                    push_request(REQ_DUMP, random_key());
                else
                    push_request(REQ_INSERT, random_key());
            end
            wait_drained();
        end

        // Final drain with a limit, then let the block settle.
        i_in_valid <= 1'b0;
        waited = 0;
        @(posedge i_clk);
        while (pending_words != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_words != 0)
            $display("%0t: %0d result words never arrived", $time, pending_words);
        if (fail_count == 0 && pending_words == 0) begin
            $display("[bounded_sorted_list_insert] OK");
        end else begin
            $display("[bounded_sorted_list_insert] ERROR");
        end
        $finish;
    end

    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("%0t: run limit reached", $time);
        $display("[bounded_sorted_list_insert] ERROR");
        $finish;
    end

endmodule
